// File: sv/g2l_pkg.sv
// Shared types, constants and lookup tables for the Gregorian to lunar date converter.
// Self-contained; g2l_if, g2l_front, g2l_step and the top level depend on it.
package g2l_pkg;

    localparam int TABLE_YEARS = 73;
    localparam int IDX_W       = $clog2(TABLE_YEARS);
    localparam int YEAR_W      = 11;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int DOY_W       = 9;
    localparam int REM_W       = 10;
    localparam int WORD_W      = 20;
    localparam int BIT_W       = 4;
    localparam int NY_W        = 6;

    localparam logic [YEAR_W-1:0]  BASE_YEAR      = 11'd1968;
    localparam logic [REM_W-1:0]   YEAR_DAYS      = 10'd365;
    localparam logic [DAY_W-1:0]   SHORT_MONTH    = 5'd29;
    localparam logic [WORD_W-1:0]  LEAP_WORD_MIN  = 20'd4095;
    localparam logic [BIT_W-1:0]   LAST_BIT_LEAP  = 4'd12;
    localparam logic [BIT_W-1:0]   LAST_BIT_PLAIN = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;

    // Lunar new year as a day count 31*(month-1)+day, one entry per year from 1968.
    localparam logic [NY_W-1:0] NY_DOY [TABLE_YEARS] = '{
        6'd30, 6'd48, 6'd37,
        6'd27, 6'd46, 6'd34, 6'd23, 6'd42, 6'd31, 6'd49, 6'd38, 6'd28, 6'd47,
        6'd36, 6'd25, 6'd44, 6'd33, 6'd51, 6'd40, 6'd50, 6'd48, 6'd37, 6'd27,
        6'd46, 6'd35, 6'd23, 6'd41, 6'd31, 6'd50, 6'd38, 6'd28, 6'd47, 6'd36,
        6'd24, 6'd43, 6'd32, 6'd22, 6'd40, 6'd29, 6'd49, 6'd38, 6'd26, 6'd45,
        6'd34, 6'd23, 6'd41, 6'd31, 6'd50, 6'd39, 6'd28, 6'd47, 6'd36, 6'd25,
        6'd43, 6'd32, 6'd22, 6'd41, 6'd29, 6'd48, 6'd37, 6'd26, 6'd44, 6'd34,
        6'd23, 6'd42, 6'd31, 6'd50, 6'd39, 6'd28, 6'd46, 6'd35, 6'd24, 6'd43
    };

    // Month-length bits (first month highest), leap month number in bits 19:16.
    localparam logic [WORD_W-1:0] LUNAR_ROM [TABLE_YEARS] = '{
        20'd461653, 20'd1386, 20'd2413,
        20'd330077, 20'd1197, 20'd2637, 20'd268877, 20'd3365, 20'd531109,
        20'd2900, 20'd2922, 20'd398042, 20'd2395,
        20'd1179, 20'd267415, 20'd2635, 20'd661067, 20'd1701, 20'd1748,
        20'd398772, 20'd2742, 20'd2391, 20'd330031,
        20'd1175, 20'd1611, 20'd200010, 20'd3749, 20'd527717, 20'd1452,
        20'd2742, 20'd332397, 20'd2350, 20'd3222,
        20'd268949, 20'd3402, 20'd3493, 20'd133973, 20'd1386, 20'd464219,
        20'd605, 20'd2349, 20'd334123, 20'd2709,
        20'd2890, 20'd267946, 20'd2773, 20'd592565, 20'd1210, 20'd2651,
        20'd395863, 20'd1323, 20'd2707, 20'd265877,
        20'd1706, 20'd2773, 20'd133557, 20'd1206, 20'd398510, 20'd2638,
        20'd3366, 20'd335142, 20'd3411, 20'd1450,
        20'd200042, 20'd2413, 20'd723293, 20'd1197, 20'd2637, 20'd399947,
        20'd3365, 20'd3410, 20'd334676, 20'd2906
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_WALK,
        ST_FIN
    } t_g2l_state;

    typedef struct packed {
        logic             bad;
        logic             pre_ny;
        logic [IDX_W-1:0] idx;
        logic [DOY_W-1:0] doy;
        logic             leap_prev;
    } t_g2l_front;

    function automatic logic [DOY_W-1:0] days_before_month_f(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] v;
        unique case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] v;
        unique case (m)
            4'd2:                      v = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        v = 5'd31;
            default:                   v = 5'd0;
        endcase
        return v;
    endfunction

    // Highest month bit of a year word: thirteen months when a leap month is coded.
    function automatic logic [BIT_W-1:0] last_bit_f(input logic [WORD_W-1:0] w);
        return (w >= LEAP_WORD_MIN) ? LAST_BIT_LEAP : LAST_BIT_PLAIN;
    endfunction

endpackage

// File: sv/g2l_if.sv
// Valid/ready channel interfaces for the date converter: Gregorian request and lunar result.
// Depends on g2l_pkg for field widths.
interface g2l_in_if;
    logic                        valid;
    logic                        ready;
    logic [g2l_pkg::YEAR_W-1:0]  greg_year;
    logic [g2l_pkg::MONTH_W-1:0] greg_month;
    logic [g2l_pkg::DAY_W-1:0]   greg_day;

    modport source (output valid, greg_year, greg_month, greg_day, input ready);
    modport sink   (input valid, greg_year, greg_month, greg_day, output ready);
    modport mon    (input valid, ready, greg_year, greg_month, greg_day);
endinterface

interface g2l_out_if;
    logic                        valid;
    logic                        ready;
    logic [g2l_pkg::YEAR_W-1:0]  lunar_year;
    logic [g2l_pkg::MONTH_W-1:0] lunar_month;
    logic                        leap_month;
    logic [g2l_pkg::DAY_W-1:0]   lunar_day;
    logic                        bad_input;

    modport source (output valid, lunar_year, lunar_month, leap_month, lunar_day, bad_input,
                    input ready);
    modport sink   (input valid, lunar_year, lunar_month, leap_month, lunar_day, bad_input,
                    output ready);
    modport mon    (input valid, ready, lunar_year, lunar_month, leap_month, lunar_day,
                    bad_input);
endinterface

// File: sv/g2l_front.sv
// Date check and day-of-year front end: validates the Gregorian date and picks the table year.
// Depends on g2l_pkg.
module g2l_front (
    input  logic [g2l_pkg::YEAR_W-1:0]  i_year,
    input  logic [g2l_pkg::MONTH_W-1:0] i_month,
    input  logic [g2l_pkg::DAY_W-1:0]   i_day,
    output g2l_pkg::t_g2l_front         o_front
);
    import g2l_pkg::*;

    logic               leap_y;
    logic               month_ok;
    logic               day_ok;
    logic               year_ok;
    logic [DAY_W-1:0]   mlen;
    logic [YEAR_W-1:0]  year_off;
    logic [IDX_W-1:0]   idx;
    logic [MONTH_W-1:0] mm1;
    logic [DOY_W-1:0]   key;
    logic               pre_ny;

    // Within the table span every fourth year is a leap year (2000 included).
    assign leap_y   = (i_year[1:0] == 2'b00);
    assign month_ok = (i_month >= MONTH_JAN) && (i_month <= MONTH_DEC);
    assign mlen     = month_len_f(i_month) + {4'd0, (i_month == MONTH_FEB) && leap_y};
    assign day_ok   = (i_day != '0) && (i_day <= mlen);
    assign year_off = i_year - BASE_YEAR;
    assign year_ok  = (i_year >= BASE_YEAR) && (year_off < YEAR_W'(TABLE_YEARS));
    assign idx      = year_ok ? year_off[IDX_W-1:0] : '0;

    // Compare month/day against the new year in the same 31-day-month count.
    assign mm1    = i_month - MONTH_JAN;
    assign key    = (DOY_W'(mm1) << 5) - DOY_W'(mm1) + DOY_W'(i_day);
    assign pre_ny = key < DOY_W'(NY_DOY[idx]);

    always_comb begin
        o_front.bad       = !month_ok || !day_ok || !year_ok || (pre_ny && (idx == '0));
        o_front.pre_ny    = pre_ny;
        o_front.idx       = pre_ny ? (idx - IDX_W'(1)) : idx;
        o_front.doy       = days_before_month_f(i_month) + DOY_W'(i_day)
                            + {8'd0, (i_month > MONTH_FEB) && leap_y};
        o_front.leap_prev = (i_year[1:0] == 2'b01);
    end

endmodule

// File: sv/g2l_step.sv
// Month step unit: tests whether the remaining day count fits in one lunar month.
// Depends on g2l_pkg.
module g2l_step (
    input  logic [g2l_pkg::REM_W-1:0] i_rem,
    input  logic                      i_long,
    output logic                      o_fit,
    output logic [g2l_pkg::REM_W-1:0] o_rem_next
);
    import g2l_pkg::*;

    logic [REM_W-1:0] len;

    assign len        = REM_W'(SHORT_MONTH) + REM_W'(i_long);
    assign o_fit      = (i_rem <= len);
    assign o_rem_next = i_rem - len;

endmodule

// File: sv/gregorian_to_lunar_date.sv
// Gregorian to Chinese lunar date converter, top level: sequencer, month walk and result register.
// Depends on g2l_pkg, g2l_if, g2l_front and g2l_step.
//
// Usage:
//   i_req carries one Gregorian date (greg_year, greg_month, greg_day); it transfers when
//   valid and ready are both high. o_rsp carries one lunar date per request (lunar_year,
//   lunar_month, leap_month, lunar_day, bad_input) and transfers on valid and ready.
//   A date with a bad month, a zero day, a day past the month end, a year outside the table
//   or a date before its first new year returns bad_input = 1 with all other fields zero.
// Timing:
//   After a transfer in, the date is checked in ST_CHECK and the walk set up in ST_START.
//   The walk then passes lunar months in ST_WALK, through the single month step unit,
//   over at most two table years. ST_FIN loads the result register once it is free;
//   a date rejected by the check skips the walk and goes straight to ST_FIN.
//   i_req.ready is high only while the sequencer is idle, so one date is in work
//   at a time.
// Reset and stalls:
//   i_rst_n (synchronous, active low) returns the sequencer to idle and drops any
//   pending result. A finished result waits in the output register while the receiver
//   stalls; a new request is still taken meanwhile, and its result holds in the final
//   step until the output register frees up.
module gregorian_to_lunar_date (
    input  logic       i_clk,
    input  logic       i_rst_n,
    g2l_in_if.sink     i_req,
    g2l_out_if.source  o_rsp
);
    import g2l_pkg::*;

    t_g2l_state         r_state, n_state;

    // Captured request
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;

    // Walk state
    t_g2l_front         w_front;
    t_g2l_front         r_front;
    logic               r_bad;
    logic [REM_W-1:0]   r_rem;
    logic [IDX_W-1:0]   r_idx;
    logic [WORD_W-1:0]  r_word;
    logic [BIT_W-1:0]   r_n;
    logic               r_pass;

    // Result register
    logic               r_out_valid;
    logic [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0] r_out_month;
    logic               r_out_leap;
    logic [DAY_W-1:0]   r_out_day;
    logic               r_out_bad;

    logic               w_in_ready;
    logic               w_accept;
    logic               w_out_free;
    logic               w_load_out;
    logic               w_fit;
    logic [REM_W-1:0]   w_rem_next;
    logic               w_idx_last;
    logic               w_walk_over;
    logic [REM_W-1:0]   w_rem_init;
    logic [WORD_W-1:0]  w_next_word;
    logic [BIT_W-1:0]   w_month_bits_last;
    logic [MONTH_W-1:0] w_raw_month;
    logic [MONTH_W:0]   w_leap_next;
    logic [MONTH_W-1:0] w_month;
    logic               w_leap;

    g2l_front u_front (
        .i_year  (r_year),
        .i_month (r_month),
        .i_day   (r_day),
        .o_front (w_front)
    );

    // Month bits 12..0 of the word; r_n never leaves that range.
    g2l_step u_step (
        .i_rem      (r_rem),
        .i_long     (r_word[r_n]),
        .o_fit      (w_fit),
        .o_rem_next (w_rem_next)
    );

    assign w_accept    = i_req.valid && w_in_ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_idx_last  = (r_idx == IDX_W'(TABLE_YEARS - 1));
    // Last month of the word passed without a fit, and no further year may be used.
    assign w_walk_over = !w_fit && (r_n == '0) && (r_pass || w_idx_last);

    // Day count from the chosen new year, 1 on new year's day.
    assign w_rem_init = (r_front.pre_ny ? (YEAR_DAYS + REM_W'(r_front.leap_prev)) : '0)
                        + REM_W'(r_front.doy) + REM_W'(1) - REM_W'(NY_DOY[r_front.idx]);
    assign w_next_word = LUNAR_ROM[r_idx + IDX_W'(1)];

    // Month number from the bit position; the month after the coded one is its leap copy.
    assign w_month_bits_last = last_bit_f(r_word);
    assign w_raw_month       = w_month_bits_last - r_n + MONTH_W'(1);
    assign w_leap_next       = {1'b0, r_word[WORD_W-1 -: MONTH_W]} + (MONTH_W + 1)'(1);

    always_comb begin
        w_month = w_raw_month;
        w_leap  = 1'b0;
        if (w_month_bits_last == LAST_BIT_LEAP) begin
            if ({1'b0, w_raw_month} == w_leap_next) begin
                w_month = r_word[WORD_W-1 -: MONTH_W];
                w_leap  = 1'b1;
            end else if ({1'b0, w_raw_month} > w_leap_next) begin
                w_month = w_raw_month - MONTH_W'(1);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_CHECK;
            ST_CHECK: n_state = w_front.bad ? ST_FIN : ST_START;
            ST_START: n_state = ST_WALK;
            ST_WALK:  if (w_fit || w_walk_over) n_state = ST_FIN;
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_FIN:  w_load_out = w_out_free;
            default: begin
                w_in_ready = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_bad       <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CHECK: r_bad  <= w_front.bad;
                ST_START: r_pass <= 1'b0;
                ST_WALK: begin
                    if (w_walk_over) begin
                        r_bad <= 1'b1;
                    end else if (!w_fit && (r_n == '0)) begin
                        r_pass <= 1'b1;
                    end
                end
                default: r_pass <= r_pass;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_year  <= i_req.greg_year;
            r_month <= i_req.greg_month;
            r_day   <= i_req.greg_day;
        end
        if (r_state == ST_CHECK) begin
            r_front <= w_front;
        end
        if (r_state == ST_START) begin
            r_idx  <= r_front.idx;
            r_word <= LUNAR_ROM[r_front.idx];
            r_n    <= last_bit_f(LUNAR_ROM[r_front.idx]);
            r_rem  <= w_rem_init;
        end
        if ((r_state == ST_WALK) && !w_fit) begin
            // Drop one month off the count and advance to the next bit or table year.
            r_rem <= w_rem_next;
            if (r_n != '0) begin
                r_n <= r_n - BIT_W'(1);
            end else if (!w_walk_over) begin
                r_idx  <= r_idx + IDX_W'(1);
                r_word <= w_next_word;
                r_n    <= last_bit_f(w_next_word);
            end
        end
        if (w_load_out) begin
            r_out_bad <= r_bad;
            if (r_bad) begin
                r_out_year  <= '0;
                r_out_month <= '0;
                r_out_leap  <= 1'b0;
                r_out_day   <= '0;
            end else begin
                r_out_year  <= BASE_YEAR + YEAR_W'(r_idx);
                r_out_month <= w_month;
                r_out_leap  <= w_leap;
                r_out_day   <= r_rem[DAY_W-1:0];
            end
        end
    end

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.lunar_year  = r_out_year;
    assign o_rsp.lunar_month = r_out_month;
    assign o_rsp.leap_month  = r_out_leap;
    assign o_rsp.lunar_day   = r_out_day;
    assign o_rsp.bad_input   = r_out_bad;

endmodule

// File: sv/g2l_checker.sv
// Port-level checks for the date converter, attached to the top level by bind.
// Depends on g2l_if.
module g2l_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    g2l_in_if.sink    i_req,
    g2l_out_if.source o_rsp
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

    // A stalled result holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.lunar_year)
            && $stable(o_rsp.lunar_month) && $stable(o_rsp.leap_month)
            && $stable(o_rsp.lunar_day) && $stable(o_rsp.bad_input))
        else $error("stalled result changed");

    // Only one date in work: the request side closes after a transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while a date is in work");

    // A rejected date carries zero fields.
    a_bad_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.bad_input |-> (o_rsp.lunar_year == '0)
            && (o_rsp.lunar_month == '0) && !o_rsp.leap_month && (o_rsp.lunar_day == '0))
        else $error("rejected date with nonzero fields");

    // A converted date lies within lunar month and day bounds.
    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.bad_input |-> (o_rsp.lunar_day >= 5'd1)
            && (o_rsp.lunar_day <= 5'd30) && (o_rsp.lunar_month >= 4'd1)
            && (o_rsp.lunar_month <= 4'd12))
        else $error("converted date out of range");

endmodule

bind gregorian_to_lunar_date g2l_checker u_g2l_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
